FILE: sv/color_matrix_gamut_map_core_macros.svh
// Assertion macros for the color matrix gamut map core.
// Expects signals named clk and rst in the scope of use.
`ifndef COLOR_MATRIX_GAMUT_MAP_CORE_MACROS_SVH
`define COLOR_MATRIX_GAMUT_MAP_CORE_MACROS_SVH

// same-cycle implication
`define CMGM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMGM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/cmgm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and helpers for the color matrix gamut map.
// No dependencies.
package cmgm_pkg;

  localparam int CHANNEL_BITS   = 16;
  localparam int COEF_FRAC_BITS = 13;

  localparam int CHAN_W    = CHANNEL_BITS;
  localparam int COEF_W    = 16;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = CHAN_W + COEF_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CW        = SUM_W - COEF_FRAC_BITS;
  localparam int LWT_W     = 18;
  localparam int LSUM_W    = CW + LWT_W + 2;
  localparam int LUM_W     = LSUM_W - 16;
  localparam int DIV_BITS  = 17;
  localparam int DIV_LAT   = DIV_BITS + 1;
  localparam int REM_W     = CW + 2;
  localparam int DIFF_W    = CW + 2;
  localparam int BPROD_W   = DIFF_W + DIV_BITS + 1;
  localparam int BSH_W     = BPROD_W - 16;
  localparam int DW        = BSH_W + 1;
  localparam int OUT_LAT   = 6 + DIV_LAT + 3;

  localparam logic [DIV_BITS-1:0] ONE_Q16   = DIV_BITS'(1) << 16;
  localparam logic [SUM_W-1:0]    C_ROUND   = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [LSUM_W-1:0]   L_ROUND   = LSUM_W'(1) << 15;
  localparam logic [BPROD_W-1:0]  B_ROUND   = BPROD_W'(1) << 15;

  // BT.709 luma weights, Q0.16, summing to 1.0
  localparam logic [LWT_W-1:0] LUMA_WT [3] = '{18'd13933, 18'd46871, 18'd4732};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0, REG_ROW1, REG_ROW2, REG_MODE, REG_MAX
  } cfg_reg_t;

  localparam logic MODE_CLIP = 1'b0;

  // per-pixel data that travels beside the divider
  typedef struct packed {
    logic                  valid;
    logic                  clip;
    logic [CHAN_W-1:0]     lum;
    logic [2:0][CW-1:0]    c;
  } side_t;

  // clamp a signed value into 0..mx
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [DW-1:0] v,
                                                   input logic [CHAN_W-1:0] mx);
    logic signed [DW-1:0] mxs;
    logic [CHAN_W-1:0]    res;
    mxs = $signed(DW'({1'b0, mx}));
    if (v < 0)        res = '0;
    else if (v > mxs) res = mx;
    else              res = v[CHAN_W-1:0];
    return res;
  endfunction

endpackage

FILE: sv/color_matrix_gamut_map_core.sv
`timescale 1ns / 1ps
// Top level of the color matrix gamut map core.
// Uses cmgm_pkg, cmgm_div and color_matrix_gamut_map_core_macros.svh.
//
// Usage:
//   A pixel (red_in, green_in, blue_in) is taken at a rising edge with start
//   high and busy low. busy stays low: a new pixel may enter every cycle.
//   The converted pixel appears on red_out, green_out, blue_out with done
//   high for one cycle, in input order. Throughput is one pixel per clock;
//   latency is set by the 3x3 matrix and luma stages (6 registers), the
//   18-stage bound divider (one quotient bit per stage, then a rounding
//   stage) and the blend multiply, round and clamp stages (3 registers).
//   Results cannot be held off; the receiver must take them when done is high.
//   Registers are written through cfg_we, cfg_index and cfg_data. The user must
//   write them only while no pixel is in flight; the block does not enforce this.
//   Indexes beyond the list are ignored. Synchronous reset loads the identity
//   matrix, clip mode and a full-scale channel maximum, and drops every pixel in flight.
`include "color_matrix_gamut_map_core_macros.svh"
module color_matrix_gamut_map_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [cmgm_pkg::CHAN_W-1:0]    red_in,
  input  logic [cmgm_pkg::CHAN_W-1:0]    green_in,
  input  logic [cmgm_pkg::CHAN_W-1:0]    blue_in,
  output logic                           done,
  output logic [cmgm_pkg::CHAN_W-1:0]    red_out,
  output logic [cmgm_pkg::CHAN_W-1:0]    green_out,
  output logic [cmgm_pkg::CHAN_W-1:0]    blue_out,
  input  logic                           cfg_we,
  input  logic [cmgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmgm_pkg::ROW_W-1:0]     cfg_data
);
  import cmgm_pkg::*;

  logic [ROW_W-1:0]  matrix_row [3];
  logic              gamut_mode;
  logic [CHAN_W-1:0] channel_max;

  logic              accept;
  logic              v0, v1, v2, v3, v4, v5;
  logic [CHAN_W-1:0] src [3];
  logic signed [PROD_W-1:0] prod1 [3][3];
  logic signed [SUM_W-1:0]  sum2  [3];
  logic signed [CW-1:0]     c2 [3];
  logic signed [CW-1:0]     c3 [3];
  logic signed [CW-1:0]     c4 [3];
  logic signed [CW+LWT_W-1:0] lprod3 [3];
  logic              neg3 [3];
  logic              over3 [3];
  logic              neg4 [3];
  logic              over4 [3];
  logic signed [LSUM_W-1:0] lsum;
  logic [CHAN_W-1:0] lum4;
  logic              clip4;
  logic [REM_W-1:0]  num5 [3];
  logic [REM_W-1:0]  den5 [3];
  logic              need5 [3];
  side_t             side5;
  side_t             side_pipe [DIV_LAT];
  logic [DIV_BITS-1:0] bound [3];
  logic [DIV_BITS-1:0] blend;
  logic              need_any5;
  logic              need_pipe [DIV_LAT];
  logic              need_any6;
  side_t             side6;
  side_t             side7;
  logic signed [DIFF_W-1:0]  diff6 [3];
  logic signed [BPROD_W-1:0] prod7 [3];
  logic signed [BPROD_W-1:0] pr7 [3];
  logic [CHAN_W-1:0] res8 [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row[0] <= ROW_W'(48'h0000_0000_2000);
      matrix_row[1] <= ROW_W'(48'h0000_2000_0000);
      matrix_row[2] <= ROW_W'(48'h2000_0000_0000);
      gamut_mode    <= MODE_CLIP;
      channel_max   <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0: matrix_row[0] <= cfg_data;
        REG_ROW1: matrix_row[1] <= cfg_data;
        REG_ROW2: matrix_row[2] <= cfg_data;
        REG_MODE: gamut_mode    <= cfg_data[0];
        REG_MAX:  channel_max   <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // valid chain through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v0 <= accept; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // stage 0: input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      src[0] <= red_in;
      src[1] <= green_in;
      src[2] <= blue_in;
    end
  end

  // stage 1: nine coefficient products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod1[i][k] <= $signed(matrix_row[i][COEF_W*k +: COEF_W]) *
                       $signed({1'b0, src[k]});
      end
    end
  end

  // stage 2: row sums, round half up to integer channels
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum2[i] = SUM_W'(prod1[i][0]) + SUM_W'(prod1[i][1]) + SUM_W'(prod1[i][2]) +
                $signed(C_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c2[i] <= $signed(sum2[i][SUM_W-1:COEF_FRAC_BITS]);
    end
  end

  // stage 3: luma products and range flags
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lprod3[i] <= c2[i] * $signed(LUMA_WT[i]);
      c3[i]     <= c2[i];
      neg3[i]   <= c2[i][CW-1];
      over3[i]  <= !c2[i][CW-1] && (c2[i] > $signed(CW'({1'b0, channel_max})));
    end
  end

  // stage 4: luma sum, round, clamp; pick the clip path
  always_comb begin
    lsum = LSUM_W'(lprod3[0]) + LSUM_W'(lprod3[1]) + LSUM_W'(lprod3[2]) +
           $signed(L_ROUND);
  end

  always_ff @(posedge clk) begin
    lum4  <= clamp_chan(DW'($signed(lsum[LSUM_W-1:16])), channel_max);
    clip4 <= (gamut_mode == MODE_CLIP) ||
             !(neg3[0] || neg3[1] || neg3[2] || over3[0] || over3[1] || over3[2]);
    for (int i = 0; i < 3; i++) begin
      c4[i]    <= c3[i];
      neg4[i]  <= neg3[i];
      over4[i] <= over3[i];
    end
  end

  // stage 5: numerator and denominator of each channel bound
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (neg4[i]) begin
        num5[i] <= REM_W'(-(REM_W'(c4[i])));
        den5[i] <= REM_W'({1'b0, lum4}) - REM_W'(c4[i]);
      end else if (over4[i]) begin
        num5[i] <= REM_W'(c4[i]) - REM_W'({1'b0, channel_max});
        den5[i] <= REM_W'(c4[i]) - REM_W'({1'b0, lum4});
      end else begin
        num5[i] <= '0;
        den5[i] <= REM_W'(1);
      end
      need5[i]   <= neg4[i] || over4[i];
      side5.c[i] <= c4[i];
    end
    side5.lum   <= lum4;
    side5.clip  <= clip4;
    side5.valid <= v4 && !rst;
  end

  assign need_any5 = need5[0] || need5[1] || need5[2];

  // per-channel bound dividers
  for (genvar g = 0; g < 3; g++) begin : g_div
    cmgm_div u_div (
      .clk  (clk),
      .num  (num5[g]),
      .den  (den5[g]),
      .need (need5[g]),
      .q    (bound[g])
    );
  end

  // side data delay matching the divider
  always_ff @(posedge clk) begin
    need_pipe[0] <= need_any5;
    for (int k = 1; k < DIV_LAT; k++) begin
      need_pipe[k] <= need_pipe[k-1];
    end
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_pipe[k].valid <= 1'b0;
      end
    end else begin
      side_pipe[0] <= side5;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  // stage 6: blend factor is the largest bound
  always_ff @(posedge clk) begin
    if (bound[0] >= bound[1] && bound[0] >= bound[2]) begin
      blend <= bound[0];
    end else if (bound[1] >= bound[2]) begin
      blend <= bound[1];
    end else begin
      blend <= bound[2];
    end
    need_any6 <= need_pipe[DIV_LAT-1];
    if (rst) begin
      side6.valid <= 1'b0;
    end else begin
      side6 <= side_pipe[DIV_LAT-1];
    end
  end

  // stage 7: move each channel toward luma
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff6[i] = $signed(DIFF_W'({1'b0, side6.lum})) - DIFF_W'($signed(side6.c[i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod7[i] <= diff6[i] * $signed({1'b0, blend});
    end
    if (rst) begin
      side7.valid <= 1'b0;
    end else begin
      side7 <= side6;
    end
  end

  // stage 8: round, add, final clip, output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr7[i] = prod7[i] + $signed(B_ROUND);
      if (side7.clip) begin
        res8[i] = clamp_chan(DW'($signed(side7.c[i])), channel_max);
      end else begin
        res8[i] = clamp_chan(DW'($signed(side7.c[i])) +
                             DW'($signed(pr7[i][BPROD_W-1:16])), channel_max);
      end
    end
  end

  always_ff @(posedge clk) begin
    red_out   <= res8[0];
    green_out <= res8[1];
    blue_out  <= res8[2];
    done      <= side7.valid && !rst;
  end

  // checks
  `CMGM_ASSERT_NXT(a_latency, accept, ##(OUT_LAT-1) done, "pixel did not emerge on time")
  `CMGM_ASSERT_IMP(a_blend_range, side7.valid, blend <= ONE_Q16, "blend factor above one")
  `CMGM_ASSERT_IMP(a_blend_zero, side7.valid && !need_any6, blend == '0,
                   "blend without an out-of-range channel")

endmodule

FILE: sv/cmgm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: ceil(2^16 * num / den) for num <= den.
// One quotient bit per stage plus a rounding stage. Uses cmgm_pkg.
module cmgm_div (
  input  logic                          clk,
  input  logic [cmgm_pkg::REM_W-1:0]    num,
  input  logic [cmgm_pkg::REM_W-1:0]    den,
  input  logic                          need,
  output logic [cmgm_pkg::DIV_BITS-1:0] q
);
  import cmgm_pkg::*;

  logic [REM_W-1:0]    rem [DIV_BITS];
  logic [REM_W-1:0]    dq  [DIV_BITS];
  logic [DIV_BITS-1:0] qb  [DIV_BITS];
  logic                nd  [DIV_BITS];

  logic [REM_W-1:0] r_in [DIV_BITS];
  logic [REM_W-1:0] d_in [DIV_BITS];
  logic             ge   [DIV_BITS];

  // stage inputs: partial remainder doubles between stages
  always_comb begin
    r_in[0] = num;
    d_in[0] = den;
    for (int k = 1; k < DIV_BITS; k++) begin
      r_in[k] = {rem[k-1][REM_W-2:0], 1'b0};
      d_in[k] = dq[k-1];
    end
    for (int k = 0; k < DIV_BITS; k++) begin
      ge[k] = (r_in[k] >= d_in[k]);
    end
  end

  // one quotient bit per stage, MSB first
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_BITS; k++) begin
      rem[k] <= ge[k] ? (r_in[k] - d_in[k]) : r_in[k];
      dq[k]  <= d_in[k];
    end
    qb[0] <= DIV_BITS'(ge[0]);
    nd[0] <= need;
    for (int k = 1; k < DIV_BITS; k++) begin
      qb[k] <= {qb[k-1][DIV_BITS-2:0], ge[k]};
      nd[k] <= nd[k-1];
    end
  end

  // round up on a nonzero remainder; no bound when not needed
  always_ff @(posedge clk) begin
    if (nd[DIV_BITS-1]) begin
      q <= qb[DIV_BITS-1] + DIV_BITS'(rem[DIV_BITS-1] != '0);
    end else begin
      q <= '0;
    end
  end

endmodule
